// ===== src/b3rkg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the round key generator.
package b3rkg_pkg;

    localparam int WORD_W    = 32;
    localparam int LANES     = 4;
    localparam int KEY_SLOTS = 16;

    // Item kinds carried on the input tuser field
    localparam logic [1:0] MODE_LOAD_STATE = 2'd0;
    localparam logic [1:0] MODE_LOAD_MSG   = 2'd1;
    localparam logic [1:0] MODE_RUN        = 2'd2;

    // G function phases: per lane, a 32-bit add of three operands into a or of two into c
    localparam logic [1:0] STEP_AD_FIRST  = 2'd0;
    localparam logic [1:0] STEP_CB_FIRST  = 2'd1;
    localparam logic [1:0] STEP_AD_SECOND = 2'd2;
    localparam logic [1:0] STEP_CB_SECOND = 2'd3;

    localparam int ROT_D_FIRST  = 16;
    localparam int ROT_B_FIRST  = 12;
    localparam int ROT_D_SECOND = 8;
    localparam int ROT_B_SECOND = 7;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [LANES-1:0] row_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_KEY
    } state_t;

    typedef struct packed {
        logic       load_state;
        logic       load_msg;
        logic       start;
        logic       mix;
        logic       diag;
        logic [1:0] step;
        logic       key_load;
        logic       permute;
    } dp_cmd_t;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // Message schedule permutation applied between rounds
    function automatic logic [3:0] msg_perm(input logic [3:0] i);
        logic [3:0] r;
        unique case (i)
            4'd0:    r = 4'd2;
            4'd1:    r = 4'd6;
            4'd2:    r = 4'd3;
            4'd3:    r = 4'd10;
            4'd4:    r = 4'd7;
            4'd5:    r = 4'd0;
            4'd6:    r = 4'd4;
            4'd7:    r = 4'd13;
            4'd8:    r = 4'd1;
            4'd9:    r = 4'd11;
            4'd10:   r = 4'd12;
            4'd11:   r = 4'd5;
            4'd12:   r = 4'd9;
            4'd13:   r = 4'd14;
            4'd14:   r = 4'd15;
            default: r = 4'd8;
        endcase
        return r;
    endfunction

endpackage

// ===== src/b3rkg_dp.sv =====
`timescale 1ns / 1ps
// Datapath: loaded words, working state, four-lane G unit and key register.
module b3rkg_dp
(
    input  logic                clk,
    input  b3rkg_pkg::dp_cmd_t  cmd,
    input  logic [3:0]          word_index,
    input  b3rkg_pkg::word_t    word_value,
    output logic [63:0]         key_high,
    output logic [63:0]         key_low
);

    b3rkg_pkg::word_t [15:0] st_reg;
    b3rkg_pkg::word_t [15:0] msg_reg;
    b3rkg_pkg::word_t [15:0] m_reg;
    b3rkg_pkg::word_t [15:0] m_next;
    b3rkg_pkg::row_t         a_reg, b_reg, c_reg, d_reg;
    b3rkg_pkg::row_t         a_next, b_next, c_next, d_next;
    logic [127:0]            key_reg;

    // One phase of the G function on all four columns or diagonals
    always_comb
    begin
        logic [1:0]       bi;
        logic [1:0]       ci;
        logic [1:0]       di;
        b3rkg_pkg::word_t x;
        b3rkg_pkg::word_t sum;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        for (int lane = 0; lane < b3rkg_pkg::LANES; lane++)
        begin
            bi  = 2'(lane + (cmd.diag ? 1 : 0));
            ci  = 2'(lane + (cmd.diag ? 2 : 0));
            di  = 2'(lane + (cmd.diag ? 3 : 0));
            x   = m_reg[{cmd.diag, 2'(lane), cmd.step[1]}];
            sum = '0;
            unique case (cmd.step)
                b3rkg_pkg::STEP_AD_FIRST:
                begin
                    sum = a_reg[lane] + b_reg[bi] + x;
                    a_next[lane] = sum;
                    d_next[di] = b3rkg_pkg::ror32(d_reg[di] ^ sum,
                                                  b3rkg_pkg::ROT_D_FIRST);
                end
                b3rkg_pkg::STEP_CB_FIRST:
                begin
                    sum = c_reg[ci] + d_reg[di];
                    c_next[ci] = sum;
                    b_next[bi] = b3rkg_pkg::ror32(b_reg[bi] ^ sum,
                                                  b3rkg_pkg::ROT_B_FIRST);
                end
                b3rkg_pkg::STEP_AD_SECOND:
                begin
                    sum = a_reg[lane] + b_reg[bi] + x;
                    a_next[lane] = sum;
                    d_next[di] = b3rkg_pkg::ror32(d_reg[di] ^ sum,
                                                  b3rkg_pkg::ROT_D_SECOND);
                end
                default:
                begin
                    sum = c_reg[ci] + d_reg[di];
                    c_next[ci] = sum;
                    b_next[bi] = b3rkg_pkg::ror32(b_reg[bi] ^ sum,
                                                  b3rkg_pkg::ROT_B_SECOND);
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            m_next[i] = m_reg[b3rkg_pkg::msg_perm(4'(i))];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_state)
        begin
            st_reg[word_index] <= word_value;
        end
        if (cmd.load_msg)
        begin
            msg_reg[word_index] <= word_value;
        end
        if (cmd.start)
        begin
            for (int i = 0; i < b3rkg_pkg::LANES; i++)
            begin
                a_reg[i] <= st_reg[i];
                b_reg[i] <= st_reg[4 + i];
                c_reg[i] <= st_reg[8 + i];
                d_reg[i] <= st_reg[12 + i];
            end
            m_reg <= msg_reg;
        end
        else
        begin
            if (cmd.mix)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                c_reg <= c_next;
                d_reg <= d_next;
            end
            if (cmd.permute)
            begin
                m_reg <= m_next;
            end
        end
        if (cmd.key_load)
        begin
            key_reg <= {b_reg[2], b_reg[3], b_reg[0], b_reg[1]};
        end
    end

    assign key_high = key_reg[63:0];
    assign key_low  = key_reg[127:64];

endmodule

// ===== src/b3rkg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: item decode, round and phase sequencing, output beat handshake.
module b3rkg_ctrl
#(
    parameter int MAX_ROUNDS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [4:0]          round_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          key_number,
    output logic                last_key,
    output b3rkg_pkg::dp_cmd_t  cmd
);

    localparam int ROUND_LIMIT = (MAX_ROUNDS < b3rkg_pkg::KEY_SLOTS) ? MAX_ROUNDS
                                                                    : b3rkg_pkg::KEY_SLOTS;

    b3rkg_pkg::state_t state_reg, state_next;
    logic [4:0]        round_counter_reg, round_counter_next;
    logic [3:0]        round_idx_reg, round_idx_next;
    logic [2:0]        phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_num_reg, out_num_next;
    logic              out_last_reg, out_last_next;

    logic       accept;
    logic [4:0] cnt_sat;
    logic       start_run;
    logic       is_last;
    logic       out_free;

    assign accept    = in_valid && in_ready;
    assign cnt_sat   = (round_count > 5'(ROUND_LIMIT)) ? 5'(ROUND_LIMIT) : round_count;
    assign start_run = accept && (mode == b3rkg_pkg::MODE_RUN) && (cnt_sat != 5'd0);
    assign is_last   = ({1'b0, round_idx_reg} + 5'd1) == round_counter_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b3rkg_pkg::ST_IDLE:
            begin
                if (start_run)
                begin
                    state_next = b3rkg_pkg::ST_MIX;
                end
            end
            b3rkg_pkg::ST_MIX:
            begin
                if (phase_reg == 3'd7)
                begin
                    state_next = b3rkg_pkg::ST_KEY;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    state_next = is_last ? b3rkg_pkg::ST_IDLE : b3rkg_pkg::ST_MIX;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == b3rkg_pkg::ST_IDLE);
        cmd.load_state = accept && (mode == b3rkg_pkg::MODE_LOAD_STATE);
        cmd.load_msg   = accept && (mode == b3rkg_pkg::MODE_LOAD_MSG);
        cmd.start      = start_run;
        cmd.mix        = (state_reg == b3rkg_pkg::ST_MIX);
        cmd.diag       = phase_reg[2];
        cmd.step       = phase_reg[1:0];
        cmd.key_load   = (state_reg == b3rkg_pkg::ST_KEY) && out_free;
        cmd.permute    = cmd.key_load && !is_last;
    end

    always_comb
    begin
        round_counter_next = round_counter_reg;
        round_idx_next     = round_idx_reg;
        phase_next         = phase_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_num_next       = out_num_reg;
        out_last_next      = out_last_reg;
        if (start_run)
        begin
            round_counter_next = cnt_sat;
            round_idx_next     = '0;
            phase_next         = '0;
        end
        if (state_reg == b3rkg_pkg::ST_MIX)
        begin
            phase_next = phase_reg + 3'd1;
        end
        if (cmd.key_load)
        begin
            out_valid_next = 1'b1;
            out_num_next   = round_idx_reg;
            out_last_next  = is_last;
            if (!is_last)
            begin
                round_idx_next = round_idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= b3rkg_pkg::ST_IDLE;
            round_counter_reg <= '0;
            round_idx_reg     <= '0;
            phase_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            round_counter_reg <= round_counter_next;
            round_idx_reg     <= round_idx_next;
            phase_reg         <= phase_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign key_number = out_num_reg;
    assign last_key   = out_last_reg;

endmodule

// ===== src/blake3_round_key_generator_top.sv =====
`timescale 1ns / 1ps
// Top level of the BLAKE3 round key generator.

// The block holds sixteen 32-bit state words and sixteen 32-bit message words,
// written one beat at a time (tuser 0 loads a state word, tuser 1 a message
// word). A run beat (tuser 2) copies both sets into working registers and
// performs round_count BLAKE3 rounds, clamped to MAX_ROUNDS and to sixteen,
// emitting after each round one output beat with state words 4..7 as a 128-bit
// key, the round index and tlast on the final key. The loaded words are left
// untouched, so every run restarts from them. A run with count zero, and a beat
// with tuser 3, produce no output. Words never loaded since reset read as
// unknown. Each round runs the four-lane G unit over four phases for the
// columns and four for the diagonals, each phase doing per lane either a
// three-operand 32-bit add into a or a two-operand add into c; it then loads
// the key register and, unless the round is the last, permutes the message.
// The key step waits while the output register is full and the sink stalls.
// Input is not taken during a run. One finished key waits in the output
// register while the next round is computed.
module blake3_round_key_generator_top
#(
    parameter int MAX_ROUNDS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // word_index[3:0], word_value[35:4], round_count[40:36], zero fill [47:41]
    input  logic [47:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // key_high[63:0], key_low[127:64], key_number[131:128], zero fill [135:132]
    output logic [135:0] m_tdata,
    output logic         m_tlast
);

    b3rkg_pkg::dp_cmd_t cmd;
    logic [63:0]        key_high;
    logic [63:0]        key_low;
    logic [3:0]         key_number;

    // Sequence the run: decode beats, step the G phases, hand off keys
    b3rkg_ctrl
    #(
        .MAX_ROUNDS (MAX_ROUNDS)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .mode        (s_tuser),
        .round_count (s_tdata[40:36]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .key_number  (key_number),
        .last_key    (m_tlast),
        .cmd         (cmd)
    );

    // Hold the words and do the mixing
    b3rkg_dp u_dp
    (
        .clk        (clk),
        .cmd        (cmd),
        .word_index (s_tdata[3:0]),
        .word_value (s_tdata[35:4]),
        .key_high   (key_high),
        .key_low    (key_low)
    );

    assign m_tdata = {4'b0000, key_number, key_low, key_high};

endmodule
